FILE: design/lbcr_pkg.sv
// ----------------------------------------------------------------------------
// lbcr_pkg: shared types and codes for the line-buffered character reader
// Transaction payload structs, request queue entry and character codes.
// ----------------------------------------------------------------------------
package lbcr_pkg;

    localparam logic       FUNC_READ      = 1'b0;
    localparam logic       FUNC_CHAR      = 1'b1;

    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_EOF       = 8'd255;

    typedef struct packed {
        logic        func;
        logic [7:0]  char_code;
        logic [15:0] requester;
        logic [15:0] request_size;
    } item_t;

    typedef struct packed {
        logic [15:0] receiver;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] requester;
        logic [15:0] size;
    } req_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: design/lbcr_req_fifo.sv
// ----------------------------------------------------------------------------
// lbcr_req_fifo: pending read request queue
// Circular queue of requester id and size; the head entry is always visible.
// ----------------------------------------------------------------------------
module lbcr_req_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lbcr_pkg::fifo_ctrl_t   ctrl,
    input  lbcr_pkg::req_entry_t   push_entry,
    output lbcr_pkg::req_entry_t   head_entry,
    output lbcr_pkg::fifo_status_t status
);
    import lbcr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_entry   = entry_reg[head_reg];

    assign do_push = ctrl.push & ~status.full;
    assign do_pop  = ctrl.pop & ~status.empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entries carry no reset; the head of an empty queue is shown but never used.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_entry;
        end
    end

endmodule

FILE: design/line_buffered_char_reader_core.sv
// ----------------------------------------------------------------------------
// line_buffered_char_reader_core: line-buffered character reader
// A read request or plain character leaves the block idle; end of file goes
// through ST_EOF. A newline flush of n bytes passes ST_READ and ST_SEND once
// per byte, one memory read and one output load; ST_SEND and ST_EOF hold on stall.
// Async active-low reset empties the line and queue at once; no clear pass.
// ----------------------------------------------------------------------------
module line_buffered_char_reader_core #(
    parameter int LINE_DEPTH    = 64,
    parameter int REQUEST_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lbcr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output lbcr_pkg::result_t result
);
    import lbcr_pkg::*;

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // take one transaction
    localparam logic [1:0] ST_READ = 2'd1;   // line store read in flight
    localparam logic [1:0] ST_SEND = 2'd2;   // load a line byte into the output
    localparam logic [1:0] ST_EOF  = 2'd3;   // load the end-of-file byte

    logic [1:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;      // bytes held in the line store
    logic [LEN_W-1:0]  cnt_reg, cnt_next;      // bytes to deliver in this flush
    logic [ADDR_W-1:0] idx_reg, idx_next;      // flush read pointer
    logic [15:0]       who_reg, who_next;      // receiver of the completed request
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    // Line store: one write port, one registered read port
    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;

    fifo_ctrl_t        fifo_ctrl;
    fifo_status_t      fifo_status;
    req_entry_t        push_entry;
    req_entry_t        head_entry;

    logic              accept;
    logic              slot_free;
    logic              line_full;
    logic [LEN_W-1:0]  len_appended;
    logic [LEN_W-1:0]  flush_cnt;
    logic              last_byte;

    lbcr_req_fifo #(
        .DEPTH (REQUEST_DEPTH)
    ) u_req_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fifo_ctrl),
        .push_entry (push_entry),
        .head_entry (head_entry),
        .status     (fifo_status)
    );

    // Accept only in idle; a result waiting in the output register does not block.
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid & ~item_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Output register may load when empty or being drained this cycle.
    assign slot_free = ~res_valid_reg | ~result_stall;

    assign push_entry.requester = item.requester;
    assign push_entry.size      = item.request_size;

    assign line_full    = (len_reg == LEN_W'(LINE_DEPTH));
    assign len_appended = line_full ? len_reg : len_reg + 1'b1;

    // Flush length: min(line length after the newline, requested size)
    assign flush_cnt = (16'(len_appended) < head_entry.size) ? len_appended
                                                             : LEN_W'(head_entry.size);

    assign last_byte = ((LEN_W'(idx_reg) + 1'b1) == cnt_reg);
    assign mem_waddr = len_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        who_next       = who_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & result_stall;
        fifo_ctrl      = '0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_READ)
                    begin
                        // Drop the request when the queue is full.
                        fifo_ctrl.push = ~fifo_status.full;
                    end
                    else if (!fifo_status.empty)
                    begin
                        if (item.char_code == CHAR_BACKSPACE)
                        begin
                            if (len_reg != '0)
                            begin
                                len_next = len_reg - 1'b1;
                            end
                        end
                        else if (item.char_code == CHAR_EOF)
                        begin
                            fifo_ctrl.pop = 1'b1;
                            len_next      = '0;
                            who_next      = head_entry.requester;
                            state_next    = ST_EOF;
                        end
                        else
                        begin
                            // Append; drop when the line is full.
                            mem_we   = ~line_full;
                            len_next = len_appended;
                            if (item.char_code == CHAR_NEWLINE)
                            begin
                                fifo_ctrl.pop = 1'b1;
                                len_next      = '0;
                                who_next      = head_entry.requester;
                                cnt_next      = flush_cnt;
                                idx_next      = '0;
                                if (flush_cnt != '0)
                                begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    res_next.receiver  = who_reg;
                    res_next.data_byte = mem_rdata_reg;
                    res_next.last      = last_byte;
                    res_valid_next     = 1'b1;
                    if (last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_EOF:
            begin
                if (slot_free)
                begin
                    res_next.receiver  = who_reg;
                    res_next.data_byte = CHAR_EOF;
                    res_next.last      = 1'b1;
                    res_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        who_reg <= who_next;
        res_reg <= res_next;
    end

    // Line store; the read pointer holds through ST_READ so the data is ready in ST_SEND.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= item.char_code;
        end
        mem_rdata_reg <= line_mem[idx_reg];
    end

endmodule

FILE: design/lbcr_checker.sv
// ----------------------------------------------------------------------------
// lbcr_props: port-level checks for the line-buffered character reader
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
module lbcr_props (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input lbcr_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input lbcr_pkg::result_t result
);
    import lbcr_pkg::*;

    // Hold a stalled result transaction.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

    // No result shows while reset is applied.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // A flush in progress keeps the input side stalled until the last byte.
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall)
        else $error("input accepted in the middle of a line flush");

    // Plain characters and backspace never occupy the block.
    a_char_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.func == FUNC_CHAR
        && item.char_code != CHAR_NEWLINE && item.char_code != CHAR_EOF
        |=> !item_stall)
        else $error("block busy after a plain character");

endmodule

bind line_buffered_char_reader_core lbcr_props u_lbcr_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: verif/lbcr_checker.sv
// ----------------------------------------------------------------------------
// lbcr_checker: transaction checker for the line-buffered character reader
// Watches both channels, tracks the request queue and the line in its own
// state, and compares each delivered byte against the oldest one owed.
// ----------------------------------------------------------------------------
module lbcr_checker #(
    parameter int LINE_DEPTH    = 64,
    parameter int REQUEST_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  lbcr_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  lbcr_pkg::result_t result,
    output int                fail_count,
    output int                bytes_owed,
    output int                useful_items,
    output int                bytes_checked,
    output int                queue_drops,
    output int                line_drops
);
    import lbcr_pkg::*;

    logic [7:0]  line_bytes [LINE_DEPTH];
    int          line_len;
    logic [15:0] waiting_who  [REQUEST_DEPTH];
    logic [15:0] waiting_size [REQUEST_DEPTH];
    int          q_head;
    int          q_count;
    result_t     owed_queue [$];

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    task automatic take_oldest(output logic [15:0] who, output logic [15:0] size);
        who     = waiting_who[q_head];
        size    = waiting_size[q_head];
        q_head  = (q_head + 1) % REQUEST_DEPTH;
        q_count--;
    endtask

    task automatic predict_delivery(input item_t it);
        int          n;
        logic [15:0] who;
        logic [15:0] size;
        result_t     r;
        if (it.func == FUNC_READ) begin
            if (q_count < REQUEST_DEPTH) begin
                waiting_who[(q_head + q_count) % REQUEST_DEPTH]  = it.requester;
                waiting_size[(q_head + q_count) % REQUEST_DEPTH] = it.request_size;
                q_count++;
                useful_items++;
            end
            else
            begin
                queue_drops++;
            end
        end
        else if (q_count != 0) begin
            useful_items++;
            if (it.char_code == CHAR_BACKSPACE) begin
                if (line_len > 0)
                    line_len--;
            end
            else if (it.char_code == CHAR_EOF) begin
                take_oldest(who, size);
                line_len    = 0;
                r.receiver  = who;
                r.data_byte = CHAR_EOF;
                r.last      = 1'b1;
                owed_queue.insert(owed_queue.size(), r);
            end
            else
            begin
                if (line_len < LINE_DEPTH) begin
                    line_bytes[line_len] = it.char_code;
                    line_len++;
                end
                else
                begin
                    line_drops++;
                end
                if (it.char_code == CHAR_NEWLINE) begin
                    take_oldest(who, size);
                    n = (line_len < int'(size)) ? line_len : int'(size);
                    for (int i = 0; i < n; i++) begin
                        r.receiver  = who;
                        r.data_byte = line_bytes[i];
                        r.last      = (i == n - 1);
                        owed_queue.insert(owed_queue.size(), r);
                    end
                    line_len = 0;
                end
            end
        end
    endtask

    task automatic check_delivery(input result_t got);
        result_t want;
        if (owed_queue.size() == 0) begin
            report($sformatf("unexpected byte %h for reader %h", got.data_byte, got.receiver));
        end
        else
        begin
            want = owed_queue.pop_front();
            bytes_checked++;
            if (got.receiver !== want.receiver)
                report($sformatf("receiver %h, expected %h", got.receiver, want.receiver));
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            line_len      = 0;
            q_head        = 0;
            q_count       = 0;
            owed_queue.delete();
            fail_count    = 0;
            bytes_owed    = 0;
            useful_items  = 0;
            bytes_checked = 0;
            queue_drops   = 0;
            line_drops    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_delivery(result);
            if (item_valid && !item_stall)
                predict_delivery(item);
            bytes_owed = owed_queue.size();
        end
    end

endmodule

FILE: verif/tb_line_buffered_char_reader_core.sv
// ----------------------------------------------------------------------------
// tb_line_buffered_char_reader_core: testbench for the character reader core
// Drives read requests and keystrokes with random gaps and receiver stalls,
// including one long receiver hold-off; the checker predicts every byte.
// ----------------------------------------------------------------------------
module tb_line_buffered_char_reader_core;
    import lbcr_pkg::*;

    localparam int LINE_DEPTH    = 64;
    localparam int REQUEST_DEPTH = 8;
    localparam int RANDOM_ITEMS  = 400;
    // Start the long receiver hold-off once this many random transactions are in.
    localparam int PRESSURE_AT   = 150;
    localparam int HOLD_CYCLES   = 400;
    // Wait after the last owed byte, sized for a full-line flush of LINE_DEPTH bytes.
    localparam int DRAIN_CYCLES  = 2 * LINE_DEPTH + 40;
    // Worst case: every item a full flush, every byte stalled the longest gap.
    localparam int CYCLE_LIMIT   = 10_000_000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int fail_count;
    int bytes_owed;
    int useful_items;
    int bytes_checked;
    int queue_drops;
    int line_drops;

    int cycles;
    bit hold_off;
    bit pressure_go;
    int tx_mode;
    int tx_span;
    int sent_items;

    line_buffered_char_reader_core #(
        .LINE_DEPTH   (LINE_DEPTH),
        .REQUEST_DEPTH(REQUEST_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    lbcr_checker #(
        .LINE_DEPTH   (LINE_DEPTH),
        .REQUEST_DEPTH(REQUEST_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .bytes_owed   (bytes_owed),
        .useful_items (useful_items),
        .bytes_checked(bytes_checked),
        .queue_drops  (queue_drops),
        .line_drops   (line_drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still owed", cycles, bytes_owed);
            $display("Verification failed");
            $finish;
        end
    end

    // Idle length drawn from three bands: mostly the shortest, now and then the longest.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mode 0 never idles, mode 1 idles now and then, mode 2 idles often.
    function automatic int maybe_gap(input int mode);
        if (mode == 0)
            return 0;
        if ($urandom_range(0, (mode == 1) ? 7 : 1) == 0)
            return idle_len();
        return 0;
    endfunction

    // Receiver side: random stalls, plus the long hold-off when it is on.
    initial
    begin
        int gap;
        int rx_mode;
        int rx_span;
        gap          = 0;
        rx_mode      = 0;
        rx_span      = 0;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(50, 300);
            end
            rx_span--;
            if (gap == 0)
                gap = maybe_gap(rx_mode);
            result_stall <= hold_off || (gap > 0);
            if (gap > 0)
                gap--;
        end
    end

    // Hold the receiver off for a long stretch so the core backs up and
    // stalls its input while the sender keeps offering.
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one transaction, idling first if the current mode says so, and
    // hold it until the core takes it.
    task automatic send(input item_t x);
        int gap;
        if (tx_span == 0) begin
            tx_mode = $urandom_range(0, 2);
            tx_span = $urandom_range(20, 120);
        end
        tx_span--;
        gap = maybe_gap(tx_mode);
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        do
            @(posedge clk);
        while (item_stall);
        sent_items++;
    endtask

    // Unused fields carry random junk; the core must ignore them.
    function automatic item_t read_req(input logic [15:0] who, input logic [15:0] size);
        item_t x;
        x.func         = FUNC_READ;
        x.char_code    = 8'($urandom);
        x.requester    = who;
        x.request_size = size;
        return x;
    endfunction

    function automatic item_t key(input logic [7:0] c);
        item_t x;
        x.func         = FUNC_CHAR;
        x.char_code    = c;
        x.requester    = 16'($urandom);
        x.request_size = 16'($urandom);
        return x;
    endfunction

    function automatic logic [15:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(1, 16));
        if (r < 85)
            return 16'($urandom_range(17, 80));
        if (r < 96)
            return 16'($urandom);
        return 16'd0;
    endfunction

    // An ordinary keystroke, now and then a backspace.
    function automatic logic [7:0] typed_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return CHAR_BACKSPACE;
        do
            c = 8'($urandom);
        while (c == CHAR_BACKSPACE || c == CHAR_NEWLINE || c == CHAR_EOF);
        return c;
    endfunction

    // One random session: mostly up to two requests followed by a typed line that
    // ends in newline or end of file; sometimes a request flood or pure noise.
    task automatic random_session();
        int         r;
        int         nreq;
        int         len;
        item_t      junk;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // Overflow the request queue.
            repeat ($urandom_range(REQUEST_DEPTH + 1, REQUEST_DEPTH + 4))
                send(read_req(16'($urandom), rand_size()));
        end
        else if (r < 15) begin
            repeat ($urandom_range(1, 6)) begin
                junk.func         = 1'($urandom_range(0, 1));
                junk.char_code    = 8'($urandom);
                junk.requester    = 16'($urandom);
                junk.request_size = 16'($urandom);
                send(junk);
            end
        end
        else
        begin
            r    = $urandom_range(0, 9);
            nreq = (r < 5) ? 0 : (r < 9) ? 1 : 2;
            repeat (nreq)
                send(read_req(16'($urandom), rand_size()));
            r = $urandom_range(0, 99);
            if (r < 72)
                len = $urandom_range(0, 12);
            else if (r < 93)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 8);
            repeat (len)
                send(key(typed_char()));
            send(key(($urandom_range(0, 99) < 85) ? CHAR_NEWLINE : CHAR_EOF));
        end
    endtask

    initial
    begin
        int start_count;
        item_valid  = 1'b0;
        item        = '0;
        rst_n       = 1'b0;
        pressure_go = 1'b0;
        tx_mode     = 0;
        tx_span     = 0;
        sent_items  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Keystrokes with no reader waiting: drop them all.
        send(key(8'h61));
        send(key(CHAR_NEWLINE));
        send(key(CHAR_EOF));
        send(key(CHAR_BACKSPACE));
        // Extreme ids and sizes, including a zero-size reader.
        send(read_req(16'hFFFF, 16'hFFFF));
        send(read_req(16'h0000, 16'd1));
        send(read_req(16'h5A5A, 16'd0));
        send(read_req(16'hA5A5, 16'd3));
        // Backspace on an empty line, then edit and flush a short line.
        send(key(CHAR_BACKSPACE));
        send(key(8'h00));
        send(key(8'hFE));
        send(key(8'h7F));
        send(key(CHAR_BACKSPACE));
        send(key(CHAR_NEWLINE));
        // Size one truncates the line to its first byte.
        send(key(8'h80));
        send(key(8'h01));
        send(key(CHAR_NEWLINE));
        // Zero size retires the reader with nothing delivered.
        send(key(8'h55));
        send(key(CHAR_NEWLINE));
        // End of file discards the pending line and delivers one byte.
        send(key(8'h42));
        send(key(CHAR_EOF));
        // Queue is empty again: ignored.
        send(key(8'h33));

        start_count = sent_items;
        while (sent_items - start_count < RANDOM_ITEMS) begin
            if (sent_items - start_count >= PRESSURE_AT)
                pressure_go = 1'b1;
            random_session();
        end
        @(negedge clk);
        item_valid <= 1'b0;

        // Drain what is owed, then give the core time to show any stray byte.
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d effective transactions in and %0d delivered bytes checked,",
                 useful_items, bytes_checked);
        $display("with %0d requests dropped on a full queue and %0d keys past a full line.",
                 queue_drops, line_drops);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
design/lbcr_pkg.sv
design/lbcr_req_fifo.sv
design/line_buffered_char_reader_core.sv
design/lbcr_checker.sv
verif/lbcr_checker.sv
verif/tb_line_buffered_char_reader_core.sv
